// File: design/cdmsr_pkg.sv
// Package with payload types, pipeline constants and the arctangent table function.
`timescale 1ns / 1ps
package cdmsr_pkg;

    localparam int DIV_STEPS = 78;
    localparam int DIV_LSB_BIT = 46;
    localparam int SQRT_STEPS = 31;
    localparam int NUM_LANES = 4;
    localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;
    localparam logic signed [31:0] DEG_Q24 = 32'sd961267368;

    typedef struct packed {
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [31:0] incr_first;
        logic [30:0]        incr_second;
        logic signed [31:0] rot_second;
        logic signed [31:0] inv11;
        logic signed [31:0] inv12;
        logic signed [31:0] inv21;
        logic signed [31:0] inv22;
        logic               singular;
        logic               clipped;
    } res_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic               zero;
    } cordic_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } sqrt_t;

    typedef struct packed {
        logic [31:0] a;
        logic        neg;
        logic [63:0] rem;
        logic [34:0] q;
        logic        big;
    } div_lane_t;

    typedef struct packed {
        logic [63:0]                     dd;
        div_lane_t [NUM_LANES-1:0]       lane;
    } div_t;

    // Arctangent of two to the minus i in Q3.60: pi/4 for i zero, else from the odd power series.
    function automatic logic signed [63:0] atan_pow2(input int i);
        logic signed [63:0] sum;
        logic [63:0]        term;
        int                 e;
        sum = '0;
        if (i == 0) begin
            return PI_Q60 >>> 2;
        end
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
                term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
                if ((k & 1) != 0) begin
                    sum = sum - $signed(term);
                end
                else begin
                    sum = sum + $signed(term);
                end
            end
        end
        return sum;
    endfunction

endpackage

// File: design/cdmsr_in_if.sv
// Interface for the matrix input channel.
`timescale 1ns / 1ps
interface cdmsr_in_if;
    import cdmsr_pkg::*;
    logic valid;
    logic ready;
    mat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/cdmsr_out_if.sv
// Interface for the result output channel.
`timescale 1ns / 1ps
interface cdmsr_out_if;
    import cdmsr_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/cdmsr_cfg_if.sv
// Interface for the threshold register write channel.
`timescale 1ns / 1ps
interface cdmsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/cdmsr_cordic_cell.sv
// One vectoring step of the arctangent chain.
`timescale 1ns / 1ps
module cdmsr_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              en,
    input  cdmsr_pkg::cordic_t din,
    output cdmsr_pkg::cordic_t dout
);
    import cdmsr_pkg::*;

    localparam logic signed [63:0] ANGLE = atan_pow2(STEP);

    cordic_t st_reg;
    cordic_t st_next;
    logic signed [63:0] dx;
    logic signed [63:0] dy;

    always_comb
    begin
        dx = din.y >>> STEP;
        dy = din.x >>> STEP;
        st_next = din;
        if (din.y > 0)
        begin
            st_next.x = din.x + dx;
            st_next.y = din.y - dy;
            st_next.z = din.z + ANGLE;
        end
        else
        begin
            st_next.x = din.x - dx;
            st_next.y = din.y + dy;
            st_next.z = din.z - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign dout = st_reg;
endmodule

// File: design/cdmsr_sqrt_cell.sv
// One result bit of the integer square root chain.
`timescale 1ns / 1ps
module cdmsr_sqrt_cell #(
    parameter int K = 0
) (
    input  logic             clk,
    input  logic             en,
    input  cdmsr_pkg::sqrt_t din,
    output cdmsr_pkg::sqrt_t dout
);
    import cdmsr_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - K));

    sqrt_t       st_reg;
    sqrt_t       st_next;
    logic [63:0] trial;

    always_comb
    begin
        trial = din.r + BIT;
        st_next = din;
        if (din.v >= trial)
        begin
            st_next.v = din.v - trial;
            st_next.r = (din.r >> 1) + BIT;
        end
        else
        begin
            st_next.r = din.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign dout = st_reg;
endmodule

// File: design/cdmsr_div_cell.sv
// One quotient bit of the four restoring dividers that share the determinant.
`timescale 1ns / 1ps
module cdmsr_div_cell #(
    parameter int BITPOS = 0
) (
    input  logic            clk,
    input  logic            en,
    input  cdmsr_pkg::div_t din,
    output cdmsr_pkg::div_t dout
);
    import cdmsr_pkg::*;

    localparam int ABIT = (BITPOS >= DIV_LSB_BIT) ? BITPOS - DIV_LSB_BIT : 0;
    localparam logic [34:0] Q_BIG = 35'h2_0000_0000;

    div_t        st_reg;
    div_t        st_next;
    logic [64:0] shifted [NUM_LANES];
    logic        take [NUM_LANES];

    always_comb
    begin
        st_next = din;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            shifted[l] = {din.lane[l].rem,
                          (BITPOS >= DIV_LSB_BIT) ? din.lane[l].a[ABIT] : 1'b0};
            take[l] = shifted[l] >= {1'b0, din.dd};
            st_next.lane[l].rem = take[l] ? 64'(shifted[l] - {1'b0, din.dd})
                                          : shifted[l][63:0];
            if (din.lane[l].q > Q_BIG)
            begin
                st_next.lane[l].big = 1'b1;
            end
            else
            begin
                st_next.lane[l].q = {din.lane[l].q[33:0], take[l]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign dout = st_reg;
endmodule

// File: design/cd_matrix_to_scale_rotation_core.sv
// Top level: matrix to axis increments, rotation and inverse.
// Usage:
// The mat channel takes one 2x2 matrix in Q2.30 per transaction. The res channel
// gives one result per matrix: the two axis increments, the second axis rotation
// in degrees and the Q16.16 inverse with its singular and clipped flags.
// The cfg channel writes the 64-bit singular threshold; it is always ready and
// should be written only while no matrix is in flight.
// The input products load at the accepting edge; the product sum and setup registers,
// the 78-cell quotient chain, the rounding and assembly registers and the output register
// follow before res.valid rises. The arctangent and square root chains run beside the
// quotient chain and are delayed to match.
// Throughput is one matrix per cycle; mat.ready stays high while res keeps up.
// When res stalls, one more result is caught in a skid register and then the
// whole pipeline freezes and mat.ready falls until res takes a result.
// Reset clears all valid bits and sets the threshold to zero.
`timescale 1ns / 1ps
module cd_matrix_to_scale_rotation_core #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    cdmsr_cfg_if.sink   cfg,
    cdmsr_in_if.sink    mat,
    cdmsr_out_if.source res
);
    import cdmsr_pkg::*;

    localparam int NSTG = DIV_STEPS + 5;
    localparam int ZDLY = DIV_STEPS - CORDIC_STEPS;
    localparam int IDLY = DIV_STEPS - SQRT_STEPS;

    typedef struct packed {
        logic singular;
        logic nonpos;
    } side_t;

    typedef struct packed {
        logic [30:0] inc1;
        logic [30:0] inc2;
    } incs_t;

    logic        en;
    logic [63:0] thr_reg;
    logic [NSTG-1:0] vld_reg;

    mat_t               s1_mat_reg;
    logic signed [63:0] s1_pa_reg, s1_pb_reg;
    logic signed [63:0] s1_q11_reg, s1_q21_reg, s1_q12_reg, s1_q22_reg;
    logic signed [63:0] pa_next, pb_next, q11_next, q21_next, q12_next, q22_next;

    mat_t               s2_mat_reg;
    logic signed [63:0] s2_det_reg;
    logic [63:0]        s2_sq1_reg, s2_sq2_reg;

    logic               pos;
    logic [63:0]        adet;
    logic signed [32:0] nvals [NUM_LANES];
    logic signed [32:0] y1v, y2v;
    cordic_t            cor1_next, cor2_next;
    div_t               div_next;
    side_t              side_next;

    cordic_t cor1 [CORDIC_STEPS+1];
    cordic_t cor2 [CORDIC_STEPS+1];
    sqrt_t   sqa [SQRT_STEPS+1];
    sqrt_t   sqb [SQRT_STEPS+1];
    div_t    divc [DIV_STEPS+1];

    cordic_t cor1_s3_reg, cor2_s3_reg;
    sqrt_t   sqa_s3_reg, sqb_s3_reg;
    div_t    div_s3_reg;

    side_t              side_reg [DIV_STEPS+1];
    logic signed [64:0] zsum_reg [ZDLY];
    logic signed [64:0] zsum_next;
    incs_t              incs_reg [IDLY];

    logic signed [34:0] ztrunc;
    logic signed [66:0] prod_next, prod_reg;
    logic [31:0]        inv_next [NUM_LANES];
    logic [31:0]        inv_reg [NUM_LANES];
    logic               clip_next, clip_reg;
    logic [34:0]        qr [NUM_LANES];
    logic               rup [NUM_LANES];
    incs_t              p1_incs_reg;
    side_t              p1_side_reg;

    logic signed [66:0] rot_diff;
    res_t               p2_next, p2_reg;

    logic out_valid_reg, skid_valid_reg;
    res_t out_data_reg, skid_data_reg;
    logic out_fire, incoming;

    function automatic cordic_t cordic_init(input logic signed [32:0] y,
                                            input logic signed [32:0] x);
        cordic_t            c;
        logic signed [32:0] xa;
        logic signed [32:0] ya;
        c.zero = (x == 0) && (y == 0);
        c.z = '0;
        xa = x;
        ya = y;
        if (x < 0)
        begin
            c.z = (y >= 0) ? PI_Q60 : -PI_Q60;
            xa = -x;
            ya = -y;
        end
        c.x = 64'(xa) <<< 30;
        c.y = 64'(ya) <<< 30;
        return c;
    endfunction

    assign en = !skid_valid_reg;
    assign mat.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            thr_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], mat.valid};
        end
    end

    // Products of the matrix entries.
    assign pa_next  = mat.data.m11 * mat.data.m22;
    assign pb_next  = mat.data.m12 * mat.data.m21;
    assign q11_next = mat.data.m11 * mat.data.m11;
    assign q21_next = mat.data.m21 * mat.data.m21;
    assign q12_next = mat.data.m12 * mat.data.m12;
    assign q22_next = mat.data.m22 * mat.data.m22;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mat_reg <= mat.data;
            s1_pa_reg  <= pa_next;
            s1_pb_reg  <= pb_next;
            s1_q11_reg <= q11_next;
            s1_q21_reg <= q21_next;
            s1_q12_reg <= q12_next;
            s1_q22_reg <= q22_next;
            s2_mat_reg <= s1_mat_reg;
            s2_det_reg <= s1_pa_reg - s1_pb_reg;
            s2_sq1_reg <= 64'(s1_q11_reg) + 64'(s1_q21_reg);
            s2_sq2_reg <= 64'(s1_q12_reg) + 64'(s1_q22_reg);
        end
    end

    // Setup of the arctangent and quotient chains from the determinant sign and magnitude.
    always_comb
    begin
        pos = s2_det_reg > 0;
        adet = s2_det_reg[63] ? 64'(-s2_det_reg) : 64'(s2_det_reg);
        y1v = pos ? 33'(s2_mat_reg.m12) : -33'(s2_mat_reg.m12);
        y2v = pos ? -33'(s2_mat_reg.m21) : 33'(s2_mat_reg.m21);
        cor1_next = cordic_init(y1v, 33'(s2_mat_reg.m22));
        cor2_next = cordic_init(y2v, 33'(s2_mat_reg.m11));
        nvals[0] = 33'(s2_mat_reg.m22);
        nvals[1] = -33'(s2_mat_reg.m12);
        nvals[2] = -33'(s2_mat_reg.m21);
        nvals[3] = 33'(s2_mat_reg.m11);
        div_next.dd = adet;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            div_next.lane[l].a = nvals[l][32] ? 32'(-nvals[l]) : 32'(nvals[l]);
            div_next.lane[l].neg = nvals[l][32] != s2_det_reg[63];
            div_next.lane[l].rem = '0;
            div_next.lane[l].q = '0;
            div_next.lane[l].big = 1'b0;
        end
        side_next.singular = adet <= thr_reg;
        side_next.nonpos = !pos;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cor1_s3_reg <= cor1_next;
            cor2_s3_reg <= cor2_next;
            sqa_s3_reg  <= '{v: s2_sq1_reg >> 2, r: 64'd0};
            sqb_s3_reg  <= '{v: s2_sq2_reg >> 2, r: 64'd0};
            div_s3_reg  <= div_next;
        end
    end

    assign cor1[0] = cor1_s3_reg;
    assign cor2[0] = cor2_s3_reg;
    assign sqa[0]  = sqa_s3_reg;
    assign sqb[0]  = sqb_s3_reg;
    assign divc[0] = div_s3_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        cdmsr_cordic_cell #(.STEP(k)) u_cell1 (
            .clk(clk), .en(en), .din(cor1[k]), .dout(cor1[k+1])
        );
        cdmsr_cordic_cell #(.STEP(k)) u_cell2 (
            .clk(clk), .en(en), .din(cor2[k]), .dout(cor2[k+1])
        );
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        cdmsr_sqrt_cell #(.K(k)) u_cella (
            .clk(clk), .en(en), .din(sqa[k]), .dout(sqa[k+1])
        );
        cdmsr_sqrt_cell #(.K(k)) u_cellb (
            .clk(clk), .en(en), .din(sqb[k]), .dout(sqb[k+1])
        );
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        cdmsr_div_cell #(.BITPOS(DIV_STEPS - 1 - k)) u_cell (
            .clk(clk), .en(en), .din(divc[k]), .dout(divc[k+1])
        );
    end

    assign zsum_next = (cor1[CORDIC_STEPS].zero ? 65'sd0 : 65'(cor1[CORDIC_STEPS].z))
                     + (cor2[CORDIC_STEPS].zero ? 65'sd0 : 65'(cor2[CORDIC_STEPS].z));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            zsum_reg[0] <= zsum_next;
            for (int k = 1; k < ZDLY; k++)
            begin
                zsum_reg[k] <= zsum_reg[k-1];
            end
            incs_reg[0] <= '{inc1: sqa[SQRT_STEPS].r[30:0], inc2: sqb[SQRT_STEPS].r[30:0]};
            for (int k = 1; k < IDLY; k++)
            begin
                incs_reg[k] <= incs_reg[k-1];
            end
        end
    end

    // Quotient rounding, saturation and the degree scaling product.
    always_comb
    begin
        ztrunc = zsum_reg[ZDLY-1][64:30];
        prod_next = ztrunc * DEG_Q24;
        clip_next = 1'b0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rup[l] = !divc[DIV_STEPS].lane[l].big
                     && ({divc[DIV_STEPS].lane[l].rem, 1'b0} >= {1'b0, divc[DIV_STEPS].dd});
            qr[l] = divc[DIV_STEPS].lane[l].q + 35'(rup[l]);
            if (divc[DIV_STEPS].lane[l].neg)
            begin
                if (divc[DIV_STEPS].lane[l].big || qr[l] > 35'h0_8000_0000)
                begin
                    inv_next[l] = 32'h8000_0000;
                    clip_next = 1'b1;
                end
                else
                begin
                    inv_next[l] = 32'(-qr[l]);
                end
            end
            else
            begin
                if (divc[DIV_STEPS].lane[l].big || qr[l] > 35'h0_7FFF_FFFF)
                begin
                    inv_next[l] = 32'h7FFF_FFFF;
                    clip_next = 1'b1;
                end
                else
                begin
                    inv_next[l] = qr[l][31:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            inv_reg <= inv_next;
            clip_reg <= clip_next;
            p1_incs_reg <= incs_reg[IDLY-1];
            p1_side_reg <= side_reg[DIV_STEPS];
            p2_reg <= p2_next;
        end
    end

    always_comb
    begin
        rot_diff = (67'sd1 <<< 32) - prod_reg;
        p2_next.rot_second = 32'(rot_diff >>> 33);
        p2_next.incr_first = p1_side_reg.nonpos ? -32'({1'b0, p1_incs_reg.inc1})
                                                : 32'({1'b0, p1_incs_reg.inc1});
        p2_next.incr_second = p1_incs_reg.inc2;
        p2_next.singular = p1_side_reg.singular;
        if (p1_side_reg.singular)
        begin
            p2_next.inv11 = 32'sh0001_0000;
            p2_next.inv12 = '0;
            p2_next.inv21 = '0;
            p2_next.inv22 = 32'sh0001_0000;
            p2_next.clipped = 1'b0;
        end
        else
        begin
            p2_next.inv11 = inv_reg[0];
            p2_next.inv12 = inv_reg[1];
            p2_next.inv21 = inv_reg[2];
            p2_next.inv22 = inv_reg[3];
            p2_next.clipped = clip_reg;
        end
    end

    assign out_fire = out_valid_reg && res.ready;
    assign incoming = en && vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_data_reg <= p2_reg;
            end
            else
            begin
                out_data_reg <= p2_reg;
            end
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data = out_data_reg;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !res.ready) |=> skid_valid_reg)
        else $error("skid result dropped while the output was stalled");

    a_singular_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.data.singular && res.data.clipped))
        else $error("singular result also flagged as clipped");

endmodule
